/* rtl/cwps_pkg.sv */
// shared constants and helper functions for the column width packing stats unit
package cwps_pkg;

   localparam int DOC_W           = 32;
   localparam int CNT_W           = 32;
   localparam int WIDTH_W         = 6;
   localparam int DIST_W          = 6;
   localparam int ROWS_PER_COLUMN = 16;
   localparam int WORD_ROW_BITS   = 32;
   localparam int ROW_IDX_W       = $clog2(ROWS_PER_COLUMN);
   localparam int FILL_W          = $clog2(WORD_ROW_BITS + 1);
   localparam int SUM_W           = ((FILL_W > WIDTH_W) ? FILL_W : WIDTH_W) + 1;
   localparam int SEEN_IDX_W      = $clog2(DOC_W);
   localparam int RSP_FIELDS_W    = 3 * CNT_W + DIST_W;
   localparam int RSP_DATA_W      = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_DATA_W      = DOC_W;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef logic [CNT_W-1:0] cnt_type;

   // saturating increment of a 32-bit count
   function automatic cnt_type sat_inc(input cnt_type v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // position of the highest set bit plus one, at least one
   function automatic logic [WIDTH_W-1:0] bit_width(input logic [DOC_W-1:0] v);
      logic [WIDTH_W-1:0] w;
      w = WIDTH_W'(1);
      for (int i = 0; i < DOC_W; i++) begin
         if (v[i]) begin
            w = WIDTH_W'(i + 1);
         end
      end
      bit_width = w;
   endfunction

endpackage

/* rtl/column_width_packing_stats_unit.sv */
// column width packing statistics over streamed posting lists
//
// usage:
//  - request channel (req_*): one document number per request in req_tdata,
//    req_tlast marks the final posting of a list
//  - response channel (rsp_*): one response per list, sent after the request
//    that carries req_tlast; it holds list length, column count, word count
//    and the number of distinct column widths
//  - no configuration registers
// timing:
//  - one request per cycle sustained while the response slot is free; the
//    per-request work (gap subtract, group or, leading-one encode, word fill
//    add and compare) sits between the request register and the response register
//  - rsp_tvalid rises when a list's last request leaves the request register
// reset:
//  - synchronous, active high; clears the list state and both valid flags
// stalls:
//  - while rsp_tready is low a finished response waits in its register;
//    requests that do not end a list still flow, and a request that ends a
//    list waits in the request register until the response slot is free
module column_width_packing_stats_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request: [31:0] doc_number
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cwps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   // response: [31:0] list_length, [63:32] packed_columns, [95:64] word_count,
   //           [101:96] distinct_widths, [103:102] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cwps_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import cwps_pkg::*;

   // request register
   logic                  s1_valid_ff, s1_valid_in;
   logic [DOC_W-1:0]      s1_doc_ff, s1_doc_in;
   logic                  s1_last_ff, s1_last_in;

   // per-list state
   logic [DOC_W-1:0]      prev_ff, prev_in;
   logic                  first_ff, first_in;
   logic [ROW_IDX_W-1:0]  row_ff, row_in;
   logic [DOC_W-1:0]      group_or_ff, group_or_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   cnt_type               cols_ff, cols_in;
   cnt_type               words_ff, words_in;
   cnt_type               posts_ff, posts_in;
   logic [DOC_W-1:0]      seen_ff, seen_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // datapath
   logic                  rsp_free;
   logic                  fire;
   logic [DOC_W-1:0]      gap;
   logic [DOC_W-1:0]      or_all;
   logic [WIDTH_W-1:0]    col_w;
   logic [WIDTH_W-1:0]    col_w_m1;
   logic [SEEN_IDX_W-1:0] seen_idx;
   logic                  close_col;
   logic [SUM_W-1:0]      fill_sum;
   logic                  new_word;
   logic [FILL_W-1:0]     fill_next;
   cnt_type               posts_next;
   cnt_type               cols_next;
   cnt_type               words_next;
   logic [DOC_W-1:0]      seen_next;
   logic [DIST_W-1:0]     dist_next;

   // a request that ends a list needs the response slot, others never wait
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_tready = !s1_valid_ff || fire;

   always_comb begin
      // first posting of a list is its own gap, otherwise wrap-around difference
      gap      = first_ff ? s1_doc_ff : s1_doc_ff - prev_ff;
      or_all   = group_or_ff | gap;
      col_w    = bit_width(or_all);
      col_w_m1 = col_w - 1'b1;
      seen_idx = col_w_m1[SEEN_IDX_W-1:0];

      // group closes when full or at the end of the list
      close_col = s1_last_ff || (row_ff == ROW_IDX_W'(ROWS_PER_COLUMN - 1));

      // greedy word fill: a column that does not fit opens a new word
      fill_sum = SUM_W'(fill_ff) + SUM_W'(col_w);
      new_word = (fill_ff == '0) || (fill_sum > SUM_W'(WORD_ROW_BITS));
      if (new_word) begin
         // a column wider than a row fills its word completely
         fill_next = (SUM_W'(col_w) > SUM_W'(WORD_ROW_BITS)) ?
                     FILL_W'(WORD_ROW_BITS) : FILL_W'(col_w);
      end else begin
         fill_next = FILL_W'(fill_sum);
      end

      posts_next = sat_inc(posts_ff);
      cols_next  = close_col ? sat_inc(cols_ff) : cols_ff;
      words_next = (close_col && new_word) ? sat_inc(words_ff) : words_ff;
      seen_next  = seen_ff;
      dist_next  = dist_ff;
      if (close_col) begin
         seen_next[seen_idx] = 1'b1;
         // distinct count tracks the seen mask incrementally
         if (!seen_ff[seen_idx]) begin
            dist_next = dist_ff + 1'b1;
         end
      end
   end

   always_comb begin
      // request register
      s1_valid_in = s1_valid_ff;
      s1_doc_in   = s1_doc_ff;
      s1_last_in  = s1_last_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_doc_in   = req_tdata[DOC_W-1:0];
         s1_last_in  = req_tlast;
      end

      // list state
      prev_in     = prev_ff;
      first_in    = first_ff;
      row_in      = row_ff;
      group_or_in = group_or_ff;
      fill_in     = fill_ff;
      cols_in     = cols_ff;
      words_in    = words_ff;
      posts_in    = posts_ff;
      seen_in     = seen_ff;
      dist_in     = dist_ff;
      if (fire) begin
         prev_in = s1_doc_ff;
         if (s1_last_ff) begin
            // list done: back to the empty-list state
            first_in    = 1'b1;
            row_in      = '0;
            group_or_in = '0;
            fill_in     = '0;
            cols_in     = '0;
            words_in    = '0;
            posts_in    = '0;
            seen_in     = '0;
            dist_in     = '0;
         end else begin
            first_in = 1'b0;
            posts_in = posts_next;
            cols_in  = cols_next;
            words_in = words_next;
            seen_in  = seen_next;
            dist_in  = dist_next;
            if (close_col) begin
               row_in      = '0;
               group_or_in = '0;
               fill_in     = fill_next;
            end else begin
               row_in      = row_ff + 1'b1;
               group_or_in = or_all;
            end
         end
      end

      // response register
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({dist_next, words_next, cols_next, posts_next});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         first_ff     <= 1'b1;
         row_ff       <= '0;
         group_or_ff  <= '0;
         fill_ff      <= '0;
         cols_ff      <= '0;
         words_ff     <= '0;
         posts_ff     <= '0;
         seen_ff      <= '0;
         dist_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         row_ff       <= row_in;
         group_or_ff  <= group_or_in;
         fill_ff      <= fill_in;
         cols_ff      <= cols_in;
         words_ff     <= words_in;
         posts_ff     <= posts_in;
         seen_ff      <= seen_in;
         dist_ff      <= dist_in;
      end
      s1_doc_ff   <= s1_doc_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // running distinct count always matches the seen mask
   a_dist_matches_mask: assert property (@(posedge clock) disable iff (reset)
      dist_ff == DIST_W'($countones(seen_ff)))
      else $error("distinct width count out of step with seen mask");

   // an open word exists exactly when a word has been counted
   a_fill_vs_words: assert property (@(posedge clock) disable iff (reset)
      (words_ff == '0) == (fill_ff == '0))
      else $error("word fill and word count disagree");

   // word fill never passes the row width
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WORD_ROW_BITS))
      else $error("word fill beyond row width");

   // finishing a list leaves the state ready for a new list with a response pending
   a_list_restart: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_last_ff) |=> (first_ff && posts_ff == '0 && rsp_valid_ff))
      else $error("list end did not restart state");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the column width packing stats unit
module testbench;
   import cwps_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 10;
   // a response waits in the response register after a list ends; allow slack
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 200000;

   // per-list statistics in rsp_tdata order, list length in the lowest bits
   typedef struct packed {
      logic [DIST_W-1:0] distinct_widths;
      logic [CNT_W-1:0]  word_count;
      logic [CNT_W-1:0]  packed_columns;
      logic [CNT_W-1:0]  list_length;
   } list_stats_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predicted list state
   logic [DOC_W-1:0] prior_doc;
   bit               list_open;
   int unsigned      rows_in_group;
   logic [DOC_W-1:0] group_bits;
   int unsigned      word_fill;
   cnt_type          column_count;
   cnt_type          word_total;
   cnt_type          posting_total;
   logic [DOC_W-1:0] widths_used;

   // statistics of finished lists whose response has not come yet
   list_stats_type pending_stats[$];

   int unsigned mismatch_count = 0;
   int unsigned postings_sent  = 0;
   int unsigned lists_sent     = 0;
   int unsigned req_idle_max   = 5;
   int unsigned rsp_idle_max   = 5;
   int unsigned rsp_hold_cycles = 0;
   int unsigned rsp_ready_delay = 0;

   column_width_packing_stats_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // counts stick at all ones
   function automatic cnt_type count_up(input cnt_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // highest set bit position plus one, never below one
   function automatic int unsigned gap_width(input logic [DOC_W-1:0] bits);
      for (int i = DOC_W - 1; i >= 0; i--) begin
         if (bits[i]) return i + 1;
      end
      return 1;
   endfunction

   function automatic void clear_list_state();
      list_open     = 1'b0;
      rows_in_group = 0;
      group_bits    = '0;
      word_fill     = 0;
      column_count  = '0;
      word_total    = '0;
      posting_total = '0;
      widths_used   = '0;
   endfunction

   // advance the predicted state by one accepted request
   function automatic void absorb_posting(input logic [DOC_W-1:0] doc, input logic last);
      logic [DOC_W-1:0] gap;
      int unsigned      w;
      list_stats_type   stats;
      // first posting of a list is its own gap; later ones wrap modulo 2^32
      gap           = list_open ? doc - prior_doc : doc;
      prior_doc     = doc;
      list_open     = 1'b1;
      posting_total = count_up(posting_total);
      group_bits    = group_bits | gap;
      rows_in_group++;
      // group closes when full or when the list ends
      if (rows_in_group >= ROWS_PER_COLUMN || last) begin
         w = gap_width(group_bits);
         widths_used[w-1] = 1'b1;
         column_count = count_up(column_count);
         // greedy packing: a column that does not fit opens a new word
         if (word_fill == 0 || word_fill + w > WORD_ROW_BITS) begin
            word_total = count_up(word_total);
            word_fill  = (w > WORD_ROW_BITS) ? WORD_ROW_BITS : w;
         end else begin
            word_fill += w;
         end
         rows_in_group = 0;
         group_bits    = '0;
      end
      if (last) begin
         stats.list_length     = posting_total;
         stats.packed_columns  = column_count;
         stats.word_count      = word_total;
         stats.distinct_widths = DIST_W'($countones(widths_used));
         pending_stats.push_back(stats);
         clear_list_state();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [CNT_W-1:0] want,
                                  input logic [CNT_W-1:0] got);
      mismatch_count++;
      $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
   endtask

   // both channels are sampled at the same edge: requests feed the prediction,
   // responses are checked against the oldest prediction
   always @(posedge clock) begin : scoreboard
      list_stats_type seen;
      list_stats_type want;
      if (reset) begin
         prior_doc = '0;
         clear_list_state();
         pending_stats.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_posting(req_tdata[DOC_W-1:0], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = list_stats_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (pending_stats.size() == 0) begin
               report_mismatch("response with no list pending, list_length", '0,
                               seen.list_length);
            end else begin
               want = pending_stats.pop_front();
               if (seen.list_length !== want.list_length)
                  report_mismatch("list_length", want.list_length, seen.list_length);
               if (seen.packed_columns !== want.packed_columns)
                  report_mismatch("packed_columns", want.packed_columns,
                                  seen.packed_columns);
               if (seen.word_count !== want.word_count)
                  report_mismatch("word_count", want.word_count, seen.word_count);
               if (seen.distinct_widths !== want.distinct_widths)
                  report_mismatch("distinct_widths", CNT_W'(want.distinct_widths),
                                  CNT_W'(seen.distinct_widths));
            end
         end
      end
   end

   // response side ready: random stall after each response, plus a long
   // hold-off whenever rsp_hold_cycles is loaded
   always @(posedge clock) begin : response_ready
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_ready_delay = 0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_ready_delay = $urandom_range(0, rsp_idle_max);
         rsp_tready <= (rsp_ready_delay == 0);
      end else if (!rsp_tready) begin
         if (rsp_ready_delay > 0) rsp_ready_delay--;
         if (rsp_ready_delay == 0) rsp_tready <= 1'b1;
      end
   end

   // offer one request after a random gap and wait until it is taken
   task automatic send_posting(input logic [DOC_W-1:0] doc, input logic last);
      int unsigned pause;
      pause = $urandom_range(0, req_idle_max);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= doc;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      postings_sent++;
   endtask

   // stop offering and let every pending response come out
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one list of random length: mostly ascending numbers whose gap sizes
   // follow a per-list range, sometimes fully scrambled numbers
   task automatic send_random_list(input int unsigned len);
      logic [DOC_W-1:0] doc;
      int unsigned      floor_shift;
      bit               scrambled;
      // a floor of DOC_W makes every later gap zero
      floor_shift = $urandom_range(0, DOC_W);
      scrambled   = ($urandom_range(0, 9) == 0);
      doc         = $urandom >> $urandom_range(0, DOC_W);
      for (int unsigned i = 0; i < len; i++) begin
         if (i > 0) begin
            doc = scrambled ? $urandom
                            : doc + ($urandom >> $urandom_range(floor_shift, DOC_W));
         end
         send_posting(doc, i == len - 1);
      end
      lists_sent++;
   endtask

   task automatic test_single_posting_lists();
      // zero document: or of zero still gives width one
      send_posting('0, 1'b1);
      // widest possible gap
      send_posting('1, 1'b1);
      send_posting(32'h0000_0001, 1'b1);
      wait_for_results();
   endtask

   task automatic test_exact_word_fill();
      // full group of 16-bit width, then a final 16-bit column: row filled
      // exactly, so both columns share one word
      repeat (ROWS_PER_COLUMN) send_posting(32'h0000_8000, 1'b0);
      send_posting(32'h0001_0000, 1'b1);
      wait_for_results();
   endtask

   task automatic test_descending_wrap();
      // gap wraps to a huge value and gives a full-width column
      send_posting(32'd100, 1'b0);
      send_posting(32'd50, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_lists(input int unsigned item_goal, input int unsigned list_goal);
      int unsigned first_item;
      int unsigned first_list;
      int unsigned len;
      first_item = postings_sent;
      first_list = lists_sent;
      while (postings_sent - first_item < item_goal || lists_sent - first_list < list_goal)
      begin
         // some lists run with no idling on either side
         if ($urandom_range(0, 3) == 0) begin
            req_idle_max = 0;
            rsp_idle_max = 0;
         end else begin
            req_idle_max = 5;
            rsp_idle_max = 5;
         end
         len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 2 * ROWS_PER_COLUMN);
         send_random_list(len);
         // now and then let the pipeline run dry mid-stream
         if ($urandom_range(0, 15) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   task automatic test_response_backpressure();
      req_idle_max = 0;
      rsp_idle_max = 5;
      // load the hold-off away from the rising edge the receiver samples on
      @(negedge clock);
      rsp_hold_cycles = 300;
      @(posedge clock);
      // short lists keep list ends coming while responses are held, so the
      // request side must stall
      repeat (30) send_random_list($urandom_range(1, 4));
      wait_for_results();
   endtask

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_single_posting_lists();
      test_exact_word_fill();
      test_descending_wrap();
      test_random_lists(600, 40);
      test_response_backpressure();

      if (mismatch_count == 0 && pending_stats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
